>>> hw/rtl/mbe_pkg.sv
// Shared types and constants for the escape-time iteration block.
package mbe_pkg;

   localparam int FIELD_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int LIMB_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = 16'd255;

   typedef logic signed [FIELD_BITS-1:0] field_type;
   typedef logic [COUNT_BITS-1:0]        count_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic neg;
   } mul_stat_type;

endpackage

>>> hw/rtl/mbe_if.sv
// Valid/ready channel interfaces for request and response words.
interface mbe_req_if;
   import mbe_pkg::*;

   logic      valid;
   logic      ready;
   field_type c_re;
   field_type c_im;
   field_type z0_re;
   field_type z0_im;

   modport source (output valid, output c_re, output c_im, output z0_re, output z0_im,
                   input ready);
   modport sink   (input valid, input c_re, input c_im, input z0_re, input z0_im,
                   output ready);
endinterface

interface mbe_rsp_if;
   import mbe_pkg::*;

   logic      valid;
   logic      ready;
   count_type iterations;
   logic      in_set;

   modport source (output valid, output iterations, output in_set, input ready);
   modport sink   (input valid, input iterations, input in_set, output ready);
endinterface

>>> hw/rtl/mbe_mul.sv
// Shared sign-magnitude multiplier, one limb-by-limb partial product per cycle.
module mbe_mul #(
   parameter int WORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [WORD_BITS-1:0]   op_a,
   input  logic signed [WORD_BITS-1:0]   op_b,
   output logic [2*WORD_BITS-1:0]        product,
   output mbe_pkg::mul_stat_type         stat
);
   import mbe_pkg::*;

   localparam int LIMBS    = (WORD_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int EXT_BITS = LIMBS * LIMB_BITS;
   localparam int ACC_BITS = 2 * EXT_BITS;
   localparam int IDX_BITS = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int SH_BITS  = IDX_BITS + 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(LIMBS - 1);

   logic [WORD_BITS-1:0]   abs_a;
   logic [WORD_BITS-1:0]   abs_b;
   logic [EXT_BITS-1:0]    a_ff;
   logic [EXT_BITS-1:0]    b_ff;
   logic                   neg_ff;
   logic [IDX_BITS-1:0]    ka_ff;
   logic [IDX_BITS-1:0]    kb_ff;
   logic                   issuing_ff;
   logic [LIMB_BITS-1:0]   limb_a;
   logic [LIMB_BITS-1:0]   limb_b;
   logic [2*LIMB_BITS-1:0] pp_in;
   logic [2*LIMB_BITS-1:0] pp_ff;
   logic [SH_BITS-1:0]     psh_ff;
   logic                   pp_valid_ff;
   logic                   pp_last_ff;
   logic [ACC_BITS-1:0]    acc_ff;
   logic                   done_ff;
   logic                   last_issue;

   assign abs_a      = op_a[WORD_BITS-1] ? WORD_BITS'(-op_a) : WORD_BITS'(op_a);
   assign abs_b      = op_b[WORD_BITS-1] ? WORD_BITS'(-op_b) : WORD_BITS'(op_b);
   assign limb_a     = a_ff[ka_ff*LIMB_BITS +: LIMB_BITS];
   assign limb_b     = b_ff[kb_ff*LIMB_BITS +: LIMB_BITS];
   assign pp_in      = limb_a * limb_b;
   assign last_issue = (ka_ff == LAST_IDX) && (kb_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         pp_valid_ff <= 1'b0;
         pp_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         done_ff     <= pp_valid_ff && pp_last_ff;
         pp_valid_ff <= issuing_ff;
         pp_last_ff  <= issuing_ff && last_issue;
         if (start) begin
            issuing_ff <= 1'b1;
         end else if (issuing_ff && last_issue) begin
            issuing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= EXT_BITS'(abs_a);
         b_ff   <= EXT_BITS'(abs_b);
         neg_ff <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
         ka_ff  <= '0;
         kb_ff  <= '0;
         acc_ff <= '0;
      end else begin
         if (issuing_ff) begin
            if (kb_ff == LAST_IDX) begin
               kb_ff <= '0;
               ka_ff <= ka_ff + 1'b1;
            end else begin
               kb_ff <= kb_ff + 1'b1;
            end
         end
         if (pp_valid_ff) begin
            acc_ff <= acc_ff + (ACC_BITS'(pp_ff) << (psh_ff * LIMB_BITS));
         end
      end
      if (issuing_ff) begin
         pp_ff  <= pp_in;
         psh_ff <= SH_BITS'(ka_ff) + SH_BITS'(kb_ff);
      end
   end

   assign product   = acc_ff[2*WORD_BITS-1:0];
   assign stat.done = done_ff;
   assign stat.busy = issuing_ff || pp_valid_ff;
   assign stat.neg  = neg_ff;

   a_start_issues: assert property (@(posedge clock) disable iff (reset)
      start |=> issuing_ff)
      else $error("multiplier did not begin issuing after start");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!issuing_ff && !pp_valid_ff))
      else $error("multiplier done while partial products pending");

   a_pp_from_issue: assert property (@(posedge clock) disable iff (reset)
      pp_valid_ff |-> $past(issuing_ff))
      else $error("partial product without issue");

endmodule

>>> hw/rtl/mandelbrot_escape_time.sv
// Escape-time counter: iterates z = z*z + c on one shared multiplier.
// Each step makes three passes through the multiplier; the first step makes two more passes.
// Not ready while a word is in flight; the next word is taken in the cycle after the result is
// loaded, even if it has not been read. Synchronous active-high reset; max_iterations -> 255.
module mandelbrot_escape_time #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 28
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  mbe_pkg::count_type         csr_wdata,
   mbe_req_if.sink                    req_if,
   mbe_rsp_if.source                  rsp_if
);
   import mbe_pkg::*;

   localparam int TAKE_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int CMP_BITS  = (PROD_BITS + 1 > 2*FRAC_BITS + 3) ? PROD_BITS + 1
                                                               : 2*FRAC_BITS + 3;
   localparam logic [CMP_BITS-1:0] MAG_LIMIT = CMP_BITS'(1) << (2*FRAC_BITS + 2);

   typedef enum logic [3:0] {
      S_IDLE, S_LIMIT, S_RR, S_II, S_RI, S_UPD, S_ISS, S_MAG, S_DONE
   } state_type;

   state_type                    state_ff;
   count_type                    max_ff;
   count_type                    i_ff;
   logic                         mag_ff;
   logic signed [WORD_BITS-1:0]  cr_ff;
   logic signed [WORD_BITS-1:0]  ci_ff;
   logic signed [WORD_BITS-1:0]  zr_ff;
   logic signed [WORD_BITS-1:0]  zi_ff;
   logic [PROD_BITS-1:0]         prr_ff;
   logic [PROD_BITS-1:0]         pii_ff;
   logic signed [PROD_BITS-1:0]  sq_ff;
   logic signed [PROD_BITS-1:0]  cross_ff;
   logic                         rsp_valid_ff;
   count_type                    rsp_iter_ff;
   logic                         rsp_in_set_ff;

   logic signed [TAKE_BITS-1:0]  t_cr;
   logic signed [TAKE_BITS-1:0]  t_ci;
   logic signed [TAKE_BITS-1:0]  t_zr;
   logic signed [TAKE_BITS-1:0]  t_zi;
   logic signed [SUM_BITS-1:0]   nr_sum;
   logic signed [SUM_BITS-1:0]   ni_sum;
   logic signed [SUM_BITS-1:0]   nr_hi;
   logic signed [SUM_BITS-1:0]   ni_hi;
   logic                         fits;
   logic [CMP_BITS-1:0]          mag_sum;
   logic                         rsp_load;

   logic                         mul_start;
   logic signed [WORD_BITS-1:0]  mul_a;
   logic signed [WORD_BITS-1:0]  mul_b;
   logic [PROD_BITS-1:0]         mul_prod;
   mul_stat_type                 mul_stat;

   mbe_mul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_prod),
      .stat    (mul_stat)
   );

   assign t_cr = req_if.c_re[TAKE_BITS-1:0];
   assign t_ci = req_if.c_im[TAKE_BITS-1:0];
   assign t_zr = req_if.z0_re[TAKE_BITS-1:0];
   assign t_zi = req_if.z0_im[TAKE_BITS-1:0];

   // new z: floor shift of the exact products, plus c
   assign nr_sum = SUM_BITS'(sq_ff >>> FRAC_BITS) + SUM_BITS'(cr_ff);
   assign ni_sum = SUM_BITS'(cross_ff >>> (FRAC_BITS - 1)) + SUM_BITS'(ci_ff);
   assign nr_hi  = nr_sum >>> (WORD_BITS - 1);
   assign ni_hi  = ni_sum >>> (WORD_BITS - 1);
   assign fits   = ((nr_hi == '0) || (nr_hi == '1)) && ((ni_hi == '0) || (ni_hi == '1));

   assign mag_sum = CMP_BITS'(prr_ff) + CMP_BITS'(pii_ff);

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      mul_start = 1'b0;
      mul_a     = zr_ff;
      mul_b     = zr_ff;
      case (state_ff)
         S_LIMIT: begin
            if (i_ff != max_ff) begin
               mul_start = 1'b1;
               if (mag_ff) begin
                  mul_b = zi_ff;
               end
            end
         end
         S_ISS: begin
            mul_start = 1'b1;
         end
         S_RR: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = zi_ff;
               mul_b     = zi_ff;
            end
         end
         S_II: begin
            if (mul_stat.done && !mag_ff) begin
               mul_start = 1'b1;
               mul_b     = zi_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_ff       <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  cr_ff    <= WORD_BITS'(t_cr);
                  ci_ff    <= WORD_BITS'(t_ci);
                  zr_ff    <= WORD_BITS'(t_zr);
                  zi_ff    <= WORD_BITS'(t_zi);
                  i_ff     <= '0;
                  mag_ff   <= 1'b0;
                  state_ff <= S_LIMIT;
               end
            end
            S_LIMIT: begin
               if (i_ff == max_ff) begin
                  state_ff <= S_DONE;
               end else if (mag_ff) begin
                  state_ff <= S_RI;
               end else begin
                  state_ff <= S_RR;
               end
            end
            S_RR: begin
               if (mul_stat.done) begin
                  prr_ff   <= mul_prod;
                  state_ff <= S_II;
               end
            end
            S_II: begin
               if (mul_stat.done) begin
                  pii_ff   <= mul_prod;
                  state_ff <= mag_ff ? S_MAG : S_RI;
               end
            end
            S_RI: begin
               if (mul_stat.done) begin
                  cross_ff <= mul_stat.neg ? signed'(-mul_prod) : signed'(mul_prod);
                  sq_ff    <= signed'(prr_ff) - signed'(pii_ff);
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (fits) begin
                  zr_ff    <= WORD_BITS'(nr_sum);
                  zi_ff    <= WORD_BITS'(ni_sum);
                  mag_ff   <= 1'b1;
                  state_ff <= S_ISS;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_ISS: begin
               state_ff <= S_RR;
            end
            S_MAG: begin
               if (mag_sum > MAG_LIMIT) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_LIMIT;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_iter_ff   <= i_ff;
                  rsp_in_set_ff <= (i_ff == max_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready      = (state_ff == S_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.iterations = rsp_iter_ff;
   assign rsp_if.in_set     = rsp_in_set_ff;

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_mag_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAG) |-> mag_ff)
      else $error("magnitude check before first update");

   a_accept_init: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> ((state_ff == S_LIMIT) && (i_ff == '0) && !mag_ff))
      else $error("word accepted without loop initialization");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rsp_valid_ff && !rsp_if.ready) |=> (state_ff == S_DONE))
      else $error("result dropped while output stalled");

endmodule
